// ----- hdl/pcc_pkg.sv -----
// Shared constants and types for the planar/chunky converter.
package pcc_pkg;

   localparam int PLANES       = 4;
   localparam int DATA_W       = 8;
   localparam int WORD_W       = 16;
   localparam int GROUP_PIXELS = 16;
   localparam int GROUP_BYTES  = 2 * PLANES;
   localparam int POS_W        = 4;
   localparam int PLANE_W      = (PLANES > 1) ? $clog2(PLANES) : 1;
   localparam int COLOUR_MAX   = (1 << PLANES) - 1;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [PLANE_W-1:0] plane_idx_type;
   typedef logic [PLANES-1:0][WORD_W-1:0] words_type;

   localparam logic DIR_DECODE = 1'b0;
   localparam logic DIR_ENCODE = 1'b1;

   typedef struct packed {
      logic      encode;
      logic      err;
      words_type words;
   } group_type;

endpackage

// ----- hdl/pcc_gather.sv -----
// Input side: collects one group of planar bytes or pixels into plane words.
module pcc_gather (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic              csr_direction,
   input  logic              req_accept,
   input  pcc_pkg::data_type req_data_in,
   input  logic              req_frame_start,
   output logic              at_last,
   output logic              grp_load,
   output pcc_pkg::group_type grp
);
   import pcc_pkg::*;

   logic          dir_ff;
   words_type     words_ff;
   pos_type       pos_ff;
   logic          err_ff;

   words_type     words_base;
   pos_type       pos_base;
   logic          err_base;
   words_type     words_in;
   logic          err_in;
   logic [POS_W:0] pos_in;
   logic          done;
   plane_idx_type plane;
   logic          over_range;
   logic [PLANES-1:0] colour;

   always_comb begin
      words_base = req_frame_start ? '0 : words_ff;
      pos_base   = req_frame_start ? '0 : pos_ff;
      err_base   = req_frame_start ? 1'b0 : err_ff;
      words_in   = words_base;
      err_in     = err_base;
      pos_in     = {1'b0, pos_base} + (POS_W+1)'(1);
      plane      = PLANE_W'(pos_base >> 1);
      over_range = (32'(req_data_in) > 32'(COLOUR_MAX));
      colour     = over_range ? '0 : req_data_in[PLANES-1:0];
      if (dir_ff == DIR_DECODE) begin
         if (!pos_base[0]) begin
            words_in[plane][WORD_W-1:DATA_W] = req_data_in;
         end else begin
            words_in[plane][DATA_W-1:0] = req_data_in;
         end
         done = (pos_in == (POS_W+1)'(GROUP_BYTES));
      end else begin
         if (over_range) begin
            err_in = 1'b1;
         end
         for (int p = 0; p < PLANES; p++) begin
            if (colour[p]) begin
               words_in[p][~pos_base] = 1'b1;
            end
         end
         done = (pos_in == (POS_W+1)'(GROUP_PIXELS));
      end
   end

   assign at_last = (dir_ff == DIR_DECODE) ? (pos_ff == POS_W'(GROUP_BYTES - 1))
                                           : (pos_ff == POS_W'(GROUP_PIXELS - 1));
   assign grp_load   = req_accept && done;
   assign grp.encode = dir_ff;
   assign grp.err    = err_in;
   assign grp.words  = words_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DIR_DECODE;
         words_ff <= '0;
         pos_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (csr_write) begin
         dir_ff   <= csr_direction;
         words_ff <= '0;
         pos_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (req_accept) begin
         if (done) begin
            words_ff <= '0;
            pos_ff   <= '0;
            err_ff   <= 1'b0;
         end else begin
            words_ff <= words_in;
            pos_ff   <= pos_in[POS_W-1:0];
            err_ff   <= err_in;
         end
      end
   end

endmodule

// ----- hdl/pcc_emit.sv -----
// Output side: holds a finished group and sends its results one per transfer.
module pcc_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               grp_load,
   input  pcc_pkg::group_type grp,
   output logic               busy,
   output logic               grp_encode,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output pcc_pkg::data_type  rsp_value_out,
   output logic               rsp_last_of_group,
   output logic               rsp_pixel_error
);
   import pcc_pkg::*;

   group_type     grp_ff;
   logic          busy_ff;
   pos_type       idx_ff;
   plane_idx_type plane;
   logic [WORD_W-1:0] word;
   logic [PLANES-1:0] pixel;
   logic          last;

   always_comb begin
      plane = PLANE_W'(idx_ff >> 1);
      word  = grp_ff.words[plane];
      for (int p = 0; p < PLANES; p++) begin
         pixel[p] = grp_ff.words[p][~idx_ff];
      end
      if (grp_ff.encode == DIR_ENCODE) begin
         rsp_value_out   = idx_ff[0] ? word[DATA_W-1:0] : word[WORD_W-1:DATA_W];
         last            = (idx_ff == POS_W'(GROUP_BYTES - 1));
         rsp_pixel_error = grp_ff.err;
      end else begin
         rsp_value_out   = DATA_W'(pixel);
         last            = (idx_ff == POS_W'(GROUP_PIXELS - 1));
         rsp_pixel_error = 1'b0;
      end
   end

   // buffer frees at the final transfer, so the next group can load in that cycle
   assign rsp_valid         = busy_ff;
   assign rsp_last_of_group = last;
   assign busy              = busy_ff && !(!rsp_stall && last);
   assign grp_encode        = grp_ff.encode;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (grp_load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && !rsp_stall) begin
         if (last) begin
            busy_ff <= 1'b0;
            idx_ff  <= '0;
         end else begin
            idx_ff <= idx_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         grp_ff <= grp;
      end
   end

endmodule

// ----- hdl/planar_chunky_converter_unit.sv -----
// Top level of the planar/chunky converter.
//
//  port group  | dir | carries
//  req_*       | in  | planar byte or pixel index, frame start
//  rsp_*       | out | pixel index or planar byte, group end, pixel error
//  csr_*       | in  | direction register write
//
// One input transfer per cycle while a group fills; the finished group is
// copied to an output buffer that sends one result per cycle (16 pixels or
// 8 bytes) unless rsp_stall holds it. The item that completes a group waits
// until the buffer sends the last result of the previous group. Decode: 8 bytes
// in, 16 results out per group, so the output buffer sets the pace. Synchronous
// reset empties the buffer and clears direction and group state.
module planar_chunky_converter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic              csr_direction,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcc_pkg::data_type req_data_in,
   input  logic              req_frame_start,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcc_pkg::data_type rsp_value_out,
   output logic              rsp_last_of_group,
   output logic              rsp_pixel_error
);
   import pcc_pkg::*;

   logic      at_last;
   logic      busy;
   logic      req_accept;
   logic      grp_load;
   logic      grp_encode;
   group_type grp;

   assign req_stall  = at_last && busy;
   assign req_accept = req_valid && !req_stall;

   pcc_gather u_gather (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_direction   (csr_direction),
      .req_accept      (req_accept),
      .req_data_in     (req_data_in),
      .req_frame_start (req_frame_start),
      .at_last         (at_last),
      .grp_load        (grp_load),
      .grp             (grp)
   );

   pcc_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .grp_load          (grp_load),
      .grp               (grp),
      .busy              (busy),
      .grp_encode        (grp_encode),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_value_out     (rsp_value_out),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_pixel_error   (rsp_pixel_error)
   );

   // a new group never lands on a buffer that is still sending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      grp_load |-> !busy)
      else $error("group loaded while output buffer busy");

   // the final transfer of a group empties the buffer unless a new group loads
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_of_group && !grp_load |=> !rsp_valid)
      else $error("output buffer still valid after group end");

   // pixel error only in encode mode; decoded pixels stay in colour range
   a_decode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (grp_encode == DIR_DECODE) |->
         !rsp_pixel_error && (32'(rsp_value_out) <= 32'(COLOUR_MAX)))
      else $error("bad decode result");

endmodule

// ----- sim/pcc_result_checker.sv -----
// Result checker for the planar/chunky converter: predicts every transfer and compares.
module pcc_result_checker
   import pcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_write,
   input  logic     csr_direction,
   input  logic     req_valid,
   input  logic     req_stall,
   input  data_type req_data_in,
   input  logic     req_frame_start,
   input  logic     rsp_valid,
   input  logic     rsp_stall,
   input  data_type rsp_value_out,
   input  logic     rsp_last_of_group,
   input  logic     rsp_pixel_error,
   output int       mismatches,
   output int       outstanding
);

   typedef struct packed {
      data_type value;
      logic     last;
      logic     err;
   } result_type;

   result_type        expected_results[$];
   logic [WORD_W-1:0] plane_acc[PLANES];
   int                fill;
   logic              err_seen;
   logic              encode_mode;

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void restart_group();
      for (int p = 0; p < PLANES; p++) plane_acc[p] = '0;
      fill = 0;
      err_seen = 1'b0;
   endfunction

   function automatic void predict(input data_type data, input logic start);
      result_type          r;
      logic [PLANES-1:0]   colour;
      data_type            pix;
      logic [WORD_W-1:0]   w;
      int                  p;
      if (start) restart_group();
      if (!encode_mode) begin
         p = fill >> 1;
         if (fill % 2 == 0) plane_acc[p][15:8] = data;
         else plane_acc[p][7:0] = data;
         fill++;
         if (fill == GROUP_BYTES) begin
            for (int x = 0; x < GROUP_PIXELS; x++) begin
               for (int q = 0; q < PLANES; q++) colour[q] = plane_acc[q][15-x];
               r.value = data_type'(colour);
               r.last  = (x == GROUP_PIXELS - 1);
               r.err   = 1'b0;
               expected_results.push_back(r);
            end
            restart_group();
         end
      end else begin
         pix = data;
         if (pix > COLOUR_MAX) begin
            err_seen = 1'b1;
            pix = '0;
         end
         for (int q = 0; q < PLANES; q++)
            if (pix[q]) plane_acc[q][15-fill] = 1'b1;
         fill++;
         if (fill == GROUP_PIXELS) begin
            for (int k = 0; k < GROUP_BYTES; k++) begin
               w = plane_acc[k>>1];
               r.value = (k % 2 == 0) ? w[15:8] : w[7:0];
               r.last  = (k == GROUP_BYTES - 1);
               r.err   = err_seen;
               expected_results.push_back(r);
            end
            restart_group();
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         expected_results.delete();
         restart_group();
         encode_mode = (DIR_DECODE == DIR_ENCODE);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report($sformatf("unexpected result value %h", rsp_value_out));
            end else begin
               want = expected_results.pop_front();
               if (rsp_value_out !== want.value)
                  report($sformatf("value_out %h, expected %h", rsp_value_out, want.value));
               if (rsp_last_of_group !== want.last)
                  report($sformatf("last_of_group %b, expected %b",
                                   rsp_last_of_group, want.last));
               if (rsp_pixel_error !== want.err)
                  report($sformatf("pixel_error %b, expected %b",
                                   rsp_pixel_error, want.err));
            end
         end
         if (csr_write) begin
            encode_mode = (csr_direction == DIR_ENCODE);
            restart_group();
         end
         if (req_valid && !req_stall) predict(req_data_in, req_frame_start);
      end
      outstanding = expected_results.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the planar/chunky converter: clock, reset, stimulus and verdict.
module tb_top;
   import pcc_pkg::*;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_write = 1'b0;
   logic     csr_direction = DIR_DECODE;
   logic     req_valid = 1'b0;
   logic     req_stall;
   data_type req_data_in = '0;
   logic     req_frame_start = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   data_type rsp_value_out;
   logic     rsp_last_of_group;
   logic     rsp_pixel_error;
   int       mismatches;
   int       outstanding;

   planar_chunky_converter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_direction     (csr_direction),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_in       (req_data_in),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_out     (rsp_value_out),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_pixel_error   (rsp_pixel_error)
   );

   pcc_result_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_direction     (csr_direction),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_in       (req_data_in),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_out     (rsp_value_out),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_pixel_error   (rsp_pixel_error),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result-side backpressure: stretches of no, light or heavy stalling
   initial begin
      int span;
      int odds;
      forever begin
         span = $urandom_range(5, 60);
         odds = $urandom_range(0, 3);
         repeat (span) begin
            @(negedge clock);
            if (odds == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= ($urandom_range(0, 9) < odds * 3);
            end
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called and returns at a falling edge; valid stays high for back-to-back transfers
   task automatic send_item(input data_type data, input logic start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_in     <= data;
      req_frame_start <= start;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic settle(input int cycles);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_direction(input logic dir);
      csr_write     <= 1'b1;
      csr_direction <= dir;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      data_type decode_bytes[8];
      logic     phase_dirs[6];
      data_type pix;
      data_type data;
      logic     start;
      int       count;
      int       group_len;

      decode_bytes = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h80, 8'h01};
      phase_dirs   = '{DIR_ENCODE, DIR_DECODE, DIR_DECODE,
                       DIR_ENCODE, DIR_DECODE, DIR_ENCODE};

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // decode: partial group dropped by frame start, then a full group
      send_item(8'h12, 1'b0);
      send_item(8'h34, 1'b0);
      for (int i = 0; i < 8; i++) send_item(decode_bytes[i], i == 0);

      // encode: descending colours with two of them replaced by out-of-range pixels
      settle(20);
      write_direction(DIR_ENCODE);
      for (int x = 0; x < GROUP_PIXELS; x++) begin
         pix = data_type'(COLOUR_MAX - x);
         if (x == 3) pix = 8'hFF;
         if (x == 9) pix = 8'h10;
         send_item(pix, 1'b0);
      end

      for (int ph = 0; ph < 6; ph++) begin
         settle(20);
         write_direction(phase_dirs[ph]);
         if (phase_dirs[ph] == DIR_ENCODE) begin
            count = $urandom_range(16, 24);
            group_len = GROUP_PIXELS;
         end else begin
            count = $urandom_range(10, 18);
            group_len = GROUP_BYTES;
         end
         for (int i = 0; i < count; i++) begin
            if (i % group_len == 0) start = ($urandom_range(0, 2) == 0);
            else start = ($urandom_range(0, 24) == 0);
            if (phase_dirs[ph] == DIR_ENCODE) begin
               if ($urandom_range(0, 9) == 0) data = data_type'($urandom_range(16, 255));
               else data = data_type'($urandom_range(0, COLOUR_MAX));
            end else begin
               data = data_type'($urandom_range(0, 255));
            end
            send_item(data, start);
         end
      end

      settle(40);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
